// ===== src/mlfq_pkg.sv =====
// Package: shared types, states and the quantum function of the feedback scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

    localparam int ActionArrive = 0;
    localparam int ActionTick   = 1;
    localparam int QuantumExpMax = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_PICK,
        ST_RUN
    } state_t;

    // Fresh quantum: one tick, or two to the power of the level (saturated exponent)
    function automatic logic [16:0] fresh_quantum(input logic mode, input int unsigned lvl);
        int unsigned e;
        begin
            e = (lvl > QuantumExpMax) ? QuantumExpMax : lvl;
            if (!mode)
            begin
                fresh_quantum = 17'd1;
            end
            else
            begin
                fresh_quantum = 17'd1 << e;
            end
        end
    endfunction

endpackage

// ===== src/mlfq_if.sv =====
// Interfaces: request, result and configuration channels of the feedback scheduler.
`timescale 1ns / 1ps
interface mlfq_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [3:0] proc_id;
    logic [7:0] service_len;
    modport source (output valid, action, proc_id, service_len, input ready);
    modport sink (input valid, action, proc_id, service_len, output ready);
endinterface

interface mlfq_res_if;
    logic        valid;
    logic        ready;
    logic        busy_res;
    logic [3:0]  running_proc;
    logic [4:0]  run_level;
    logic        finished;
    logic        preempted;
    logic [15:0] tick_number;
    modport source (output valid, busy_res, running_proc, run_level, finished, preempted,
                    tick_number, input ready);
    modport sink (input valid, busy_res, running_proc, run_level, finished, preempted,
                  tick_number, output ready);
endinterface

interface mlfq_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/multilevel_feedback_scheduler.sv =====
// Top level: multilevel feedback queue scheduler with its queue memory.
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler. An arrive transaction (action 0) places a
// process at the tail of level 0 unless that level is full, producing no result. A
// tick transaction (action 1) passes through acceptance, preemption handling (demote
// and push, or renew the quantum), dispatch from the lowest non-empty level with a
// read of the queue memory, and the run step that registers the result. The queue
// slot memory is read through a register. The result register parts the two sides:
// a new transaction is accepted while a result waits; the run step holds only when
// the previous result has not been taken. The queue slot memory needs no clearing
// pass: an entry is read only after it was pushed. The quantum mode register may be
// written at any time the block is idle.
module multilevel_feedback_scheduler
    import mlfq_pkg::*;
#(
    parameter int NUM_PROCS  = 16,
    parameter int NUM_LEVELS = 17
)
(
    input  logic        clk,
    input  logic        rst_n,
    mlfq_req_if.sink    req,
    mlfq_res_if.source  res,
    mlfq_cfg_if.sink    cfg
);
    localparam int PW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CW    = $clog2(NUM_PROCS + 1);
    localparam int LVW   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int DEPTH = NUM_LEVELS * NUM_PROCS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(DEPTH + 1);

    // Queue slot memory, one row of NUM_PROCS slots per level
    logic [PW-1:0] slot_mem [DEPTH];
    logic [PW-1:0] rdata_reg;

    // Per-process state, read only at the running process
    logic [7:0]     rem_mem [NUM_PROCS];
    logic [LVW-1:0] lvl_mem [NUM_PROCS];

    state_t         state_reg, state_next;
    logic [PW-1:0]  head_reg  [NUM_LEVELS];
    logic [CW-1:0]  count_reg [NUM_LEVELS];
    logic [WW-1:0]  waiting_reg;
    logic [PW-1:0]  cur_reg;
    logic           idle_reg;
    logic           pending_reg;
    logic [16:0]    quantum_reg;
    logic [15:0]    tick_reg;
    logic           mode_reg;
    logic           disp_reg;
    logic           out_valid_reg;
    logic           busy_reg, fin_reg, pre_reg;
    logic [3:0]     proc_out_reg;
    logic [4:0]     lvl_out_reg;
    logic [15:0]    tick_out_reg;

    logic           req_fire, arrive_ok, run_done;
    logic [PW-1:0]  arr_pid;
    logic           push_en;
    logic [LVW-1:0] push_lvl;
    logic [PW-1:0]  push_pid;
    logic [CW:0]    push_sum;
    logic [PW-1:0]  push_pos;
    logic [LVW-1:0] demote_lvl;
    logic           found;
    logic [LVW-1:0] found_lvl;
    logic [PW-1:0]  run_pid;
    logic [16:0]    run_q;
    logic [7:0]     run_rem;
    logic [16:0]    q_dec;
    logic [PW:0]    head_inc;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign arr_pid   = PW'(req.proc_id);
    assign arrive_ok = req_fire && (req.action == 1'(ActionArrive))
                       && (32'(req.proc_id) < NUM_PROCS);
    assign run_done  = (state_reg == ST_RUN) && (!out_valid_reg || res.ready);

    assign res.valid        = out_valid_reg;
    assign res.busy_res     = busy_reg;
    assign res.running_proc = proc_out_reg;
    assign res.run_level    = lvl_out_reg;
    assign res.finished     = fin_reg;
    assign res.preempted    = pre_reg;
    assign res.tick_number  = tick_out_reg;

    // Demoted level saturates at the last queue
    always_comb
    begin
        if (32'(lvl_mem[cur_reg]) + 1 < NUM_LEVELS)
        begin
            demote_lvl = lvl_mem[cur_reg] + LVW'(1);
        end
        else
        begin
            demote_lvl = lvl_mem[cur_reg];
        end
    end

    // Push: an arrival into level 0, or a demotion during preemption handling
    always_comb
    begin
        push_en  = 1'b0;
        push_lvl = '0;
        push_pid = arr_pid;
        if (arrive_ok)
        begin
            push_en = 1'b1;
        end
        else if (state_reg == ST_TICK && pending_reg && waiting_reg != '0)
        begin
            push_en  = 1'b1;
            push_lvl = demote_lvl;
            push_pid = cur_reg;
        end
        push_sum = (CW+1)'(head_reg[push_lvl]) + (CW+1)'(count_reg[push_lvl]);
        if (32'(push_sum) >= NUM_PROCS)
        begin
            push_sum = push_sum - (CW+1)'(NUM_PROCS);
        end
        push_pos = PW'(push_sum);
        if (32'(count_reg[push_lvl]) >= NUM_PROCS)
        begin
            push_en = 1'b0;
        end
    end

    // Lowest non-empty level
    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                found     = 1'b1;
                found_lvl = LVW'(l);
            end
        end
        head_inc = (PW+1)'(head_reg[found_lvl]) + (PW+1)'(1);
        if (32'(head_inc) >= NUM_PROCS)
        begin
            head_inc = '0;
        end
    end

    // Run step operands: a fresh dispatch takes the memory data and a new quantum
    always_comb
    begin
        run_pid = disp_reg ? rdata_reg : cur_reg;
        run_q   = disp_reg ? fresh_quantum(mode_reg, 32'(lvl_mem[run_pid])) : quantum_reg;
        run_rem = rem_mem[run_pid];
        if (run_rem != 8'd0)
        begin
            run_rem = run_rem - 8'd1;
        end
        q_dec = run_q;
        if (q_dec != 17'd0)
        begin
            q_dec = q_dec - 17'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req.action == 1'(ActionTick))
                begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: state_next = ST_PICK;
            ST_PICK: state_next = ST_RUN;
            ST_RUN:
            begin
                if (run_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Queue memory: write on push, read the head of the dispatched level
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slot_mem[AW'(32'(push_lvl) * NUM_PROCS + 32'(push_pos))] <= push_pid;
        end
        if (state_reg == ST_PICK)
        begin
            rdata_reg <= slot_mem[AW'(32'(found_lvl) * NUM_PROCS + 32'(head_reg[found_lvl]))];
        end
    end

    // Per-process state
    always_ff @(posedge clk)
    begin
        if (arrive_ok)
        begin
            rem_mem[arr_pid] <= (req.service_len == 8'd0) ? 8'd1 : req.service_len;
            lvl_mem[arr_pid] <= '0;
        end
        else if (state_reg == ST_TICK && pending_reg && waiting_reg != '0)
        begin
            lvl_mem[cur_reg] <= demote_lvl;
        end
        else if (run_done && !idle_reg)
        begin
            rem_mem[run_pid] <= run_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            waiting_reg   <= '0;
            cur_reg       <= '0;
            idle_reg      <= 1'b1;
            pending_reg   <= 1'b0;
            quantum_reg   <= '0;
            tick_reg      <= '0;
            mode_reg      <= 1'b0;
            disp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            pre_reg       <= 1'b0;
            proc_out_reg  <= '0;
            lvl_out_reg   <= '0;
            tick_out_reg  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                mode_reg <= cfg.data;
            end
            // Load a new result, or drop the taken one
            if (run_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (push_en)
            begin
                count_reg[push_lvl] <= count_reg[push_lvl] + CW'(1);
                waiting_reg         <= waiting_reg + WW'(1);
            end
            case (state_reg)
                ST_TICK:
                begin
                    // Renew the quantum when nobody else waits
                    if (pending_reg && waiting_reg == '0)
                    begin
                        idle_reg    <= 1'b0;
                        quantum_reg <= fresh_quantum(mode_reg, 32'(lvl_mem[cur_reg]));
                    end
                    pending_reg <= 1'b0;
                end
                ST_PICK:
                begin
                    disp_reg <= idle_reg && found;
                    if (idle_reg && found)
                    begin
                        head_reg[found_lvl]  <= PW'(head_inc);
                        count_reg[found_lvl] <= count_reg[found_lvl] - CW'(1);
                        waiting_reg          <= waiting_reg - WW'(1);
                        idle_reg             <= 1'b0;
                    end
                end
                ST_RUN:
                begin
                    if (run_done)
                    begin
                        tick_out_reg <= tick_reg;
                        tick_reg     <= tick_reg + 16'd1;
                        disp_reg     <= 1'b0;
                        busy_reg     <= !idle_reg;
                        fin_reg      <= !idle_reg && (run_rem == 8'd0);
                        pre_reg      <= !idle_reg && (run_rem != 8'd0) && (q_dec == 17'd0);
                        proc_out_reg <= idle_reg ? 4'd0 : 4'(run_pid);
                        lvl_out_reg  <= idle_reg ? 5'd0 : 5'(lvl_mem[run_pid]);
                        if (!idle_reg)
                        begin
                            cur_reg     <= run_pid;
                            quantum_reg <= q_dec;
                            if (run_rem == 8'd0)
                            begin
                                idle_reg <= 1'b1;
                            end
                            else if (q_dec == 17'd0)
                            begin
                                pending_reg <= 1'b1;
                                idle_reg    <= 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_multilevel_feedback_scheduler.sv =====
// Testbench: checks the feedback scheduler against a behavioral predictor.
`timescale 1ns / 1ps
module tb_multilevel_feedback_scheduler;
    import mlfq_pkg::*;

    localparam int NPROC     = 16;
    localparam int NLVL      = 17;
    localparam int WDOG_MAX  = 20000;
    localparam int STALL_LEN = 400;

    typedef struct packed {
        logic        busy_res;
        logic [3:0]  running_proc;
        logic [4:0]  run_level;
        logic        finished;
        logic        preempted;
        logic [15:0] tick_number;
    } sched_res_t;

    // Directed row: known marks whether the typed result is checked as well.
    typedef struct {
        logic       action;
        logic [3:0] pid;
        logic [7:0] len;
        logic       known;
        sched_res_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    mlfq_req_if req ();
    mlfq_res_if res ();
    mlfq_cfg_if cfg ();

    multilevel_feedback_scheduler u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    // Scheduler state mirrored by the predictor.
    logic [3:0]  slot_mem [NLVL][NPROC];
    logic [3:0]  lvl_head [NLVL];
    logic [4:0]  lvl_cnt [NLVL];
    logic [7:0]  rem_ticks [NPROC];
    logic [4:0]  plevel [NPROC];
    int          n_waiting;
    logic [3:0]  cur_pid;
    logic        cpu_free;
    logic        preempt_due;
    logic [16:0] quantum_rem;
    logic [15:0] tick_ctr;
    logic        mode_q;

    sched_res_t  sched_expect_q[$];
    sched_res_t  typed_expect_q[$];
    logic        typed_flag_q[$];

    int   errors;
    int   wdog;
    int   rx_stall_pct;
    int   tx_idle_pct;
    bit   rx_hold;

    function automatic logic [16:0] quantum_for(input logic [4:0] lvl);
        if (!mode_q)
        begin
            return 17'd1;
        end
        return 17'd1 << ((lvl > 16) ? 16 : lvl);
    endfunction

    function automatic void enqueue_level(input int lvl, input logic [3:0] pid);
        if (lvl_cnt[lvl] >= NPROC)
        begin
            return;
        end
        slot_mem[lvl][(lvl_head[lvl] + lvl_cnt[lvl]) % NPROC] = pid;
        lvl_cnt[lvl]++;
        n_waiting++;
    endfunction

    function automatic void sched_clear();
        for (int l = 0; l < NLVL; l++)
        begin
            lvl_head[l] = '0;
            lvl_cnt[l]  = '0;
        end
        n_waiting   = 0;
        cur_pid     = '0;
        cpu_free    = 1'b1;
        preempt_due = 1'b0;
        quantum_rem = '0;
        tick_ctr    = '0;
        mode_q      = 1'b0;
    endfunction

    // Advance the predictor by one transaction; return 1 with the outcome of a tick.
    function automatic bit sched_predict(input logic action, input logic [3:0] pid_in,
                                         input logic [7:0] len, output sched_res_t r);
        logic [4:0] lvl;
        logic [3:0] pid;
        r = '0;
        if (action == ActionArrive[0])
        begin
            rem_ticks[pid_in] = (len == 0) ? 8'd1 : len;
            plevel[pid_in]    = '0;
            enqueue_level(0, pid_in);
            return 1'b0;
        end
        if (preempt_due)
        begin
            if (n_waiting > 0)
            begin
                lvl = plevel[cur_pid];
                if (lvl + 1 < NLVL)
                begin
                    lvl++;
                end
                plevel[cur_pid] = lvl;
                enqueue_level(lvl, cur_pid);
            end
            else
            begin
                cpu_free    = 1'b0;
                quantum_rem = quantum_for(plevel[cur_pid]);
            end
            preempt_due = 1'b0;
        end
        if (cpu_free)
        begin
            for (int l = 0; l < NLVL; l++)
            begin
                if (lvl_cnt[l] != 0)
                begin
                    cur_pid     = slot_mem[l][lvl_head[l]];
                    lvl_head[l] = lvl_head[l] + 1;
                    lvl_cnt[l]--;
                    n_waiting--;
                    quantum_rem = quantum_for(plevel[cur_pid]);
                    cpu_free    = 1'b0;
                    break;
                end
            end
        end
        if (!cpu_free)
        begin
            pid            = cur_pid;
            r.busy_res     = 1'b1;
            r.running_proc = pid;
            r.run_level    = plevel[pid];
            if (rem_ticks[pid] > 0)
            begin
                rem_ticks[pid]--;
            end
            if (quantum_rem > 0)
            begin
                quantum_rem--;
            end
            if (rem_ticks[pid] == 0)
            begin
                r.finished = 1'b1;
                cpu_free   = 1'b1;
            end
            else if (quantum_rem == 0)
            begin
                r.preempted = 1'b1;
                preempt_due = 1'b1;
                cpu_free    = 1'b1;
            end
        end
        r.tick_number = tick_ctr;
        tick_ctr++;
        return 1'b1;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Drive one transaction, predict it, and hold until accepted. Valid stays high
    // after acceptance so the next transaction can follow with no gap; an idle
    // cycle or drain() drops it.
    task automatic send_item(input logic action, input logic [3:0] pid, input logic [7:0] len,
                             input logic known, input sched_res_t want);
        sched_res_t r;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.action      <= action;
        req.proc_id     <= pid;
        req.service_len <= len;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        if (sched_predict(action, pid, len, r))
        begin
            sched_expect_q.push_back(r);
            typed_expect_q.push_back(want);
            typed_flag_q.push_back(known);
        end
    endtask

    task automatic send_rand(input logic action, input logic [3:0] pid, input logic [7:0] len);
        send_item(action, pid, len, 1'b0, '0);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline drain.
    task automatic drain();
        req.valid <= 1'b0;
        while (sched_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg.valid <= 1'b1;
        cfg.data  <= m;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        mode_q = m;
    endtask

    // Random phase: about one third arrivals with service from 1 to maxlen, the rest ticks.
    task automatic random_phase(input int n, input int maxlen);
        int k;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(99) < 35)
            begin
                send_rand(ActionArrive[0], 4'($urandom), 8'($urandom_range(maxlen, 1)));
            end
            else
            begin
                send_rand(ActionTick[0], 4'($urandom), 8'($urandom));
            end
            k++;
        end
    endtask

    // Check results in the order the ticks were sent.
    always @(posedge clk)
    begin
        sched_res_t got;
        sched_res_t exp_r;
        sched_res_t typed;
        logic       known;
        if (rst_n && res.valid && res.ready)
        begin
            got = {res.busy_res, res.running_proc, res.run_level, res.finished,
                   res.preempted, res.tick_number};
            if (sched_expect_q.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
            end
            else
            begin
                exp_r = sched_expect_q.pop_front();
                typed = typed_expect_q.pop_front();
                known = typed_flag_q.pop_front();
                if (known && typed != exp_r)
                begin
                    $error("directed row disagrees with predictor: %h vs %h", typed, exp_r);
                    errors++;
                end
                if (got.busy_res != exp_r.busy_res)
                begin
                    $error("busy_res exp %0d got %0d", exp_r.busy_res, got.busy_res);
                    errors++;
                end
                if (got.running_proc != exp_r.running_proc)
                begin
                    $error("running_proc exp %0d got %0d", exp_r.running_proc,
                           got.running_proc);
                    errors++;
                end
                if (got.run_level != exp_r.run_level)
                begin
                    $error("run_level exp %0d got %0d", exp_r.run_level, got.run_level);
                    errors++;
                end
                if (got.finished != exp_r.finished)
                begin
                    $error("finished exp %0d got %0d", exp_r.finished, got.finished);
                    errors++;
                end
                if (got.preempted != exp_r.preempted)
                begin
                    $error("preempted exp %0d got %0d", exp_r.preempted, got.preempted);
                    errors++;
                end
                if (got.tick_number != exp_r.tick_number)
                begin
                    $error("tick_number exp %0d got %0d", exp_r.tick_number,
                           got.tick_number);
                    errors++;
                end
            end
        end
    end

    // Receiver: stall at the phase's rate, or hold off entirely during a pressure stretch.
    always @(posedge clk)
    begin
        if (rx_hold)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: count cycles with no transaction on any channel and no receiver hold.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)
            || rx_hold)
        begin
            wdog <= 0;
        end
        else
        begin
            wdog <= wdog + 1;
        end
        if (wdog >= WDOG_MAX)
        begin
            $display("** multilevel_feedback_scheduler: FAILED **");
            $finish;
        end
    end

    dir_row_t dir_tab[$];

    function automatic dir_row_t mk(input logic a, input logic [3:0] p, input logic [7:0] l,
                                    input logic k, input sched_res_t w);
        dir_row_t d;
        d.action = a;
        d.pid    = p;
        d.len    = l;
        d.known  = k;
        d.want   = w;
        return d;
    endfunction

    initial
    begin
        errors       = 0;
        wdog         = 0;
        rx_stall_pct = 0;
        tx_idle_pct  = 0;
        rx_hold      = 1'b0;
        rst_n        = 1'b0;
        req.valid       = 1'b0;
        req.action      = 1'b0;
        req.proc_id     = '0;
        req.service_len = '0;
        res.ready       = 1'b0;
        cfg.valid       = 1'b0;
        cfg.data        = 1'b0;
        sched_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle ticks after reset, extremes of pid and length, zero service,
        // demotion in mode 0, repeated arrival.
        dir_tab.push_back(mk(ActionTick[0], 4'd0, 8'd0, 1'b1, '0));
        dir_tab.push_back(mk(ActionTick[0], 4'hf, 8'hff, 1'b1, {1'b0, 4'd0, 5'd0, 1'b0,
                                                                 1'b0, 16'd1}));
        dir_tab.push_back(mk(ActionArrive[0], 4'd0, 8'd0, 1'b0, '0));
        dir_tab.push_back(mk(ActionTick[0], 4'd0, 8'd0, 1'b1, {1'b1, 4'd0, 5'd0, 1'b1,
                                                                1'b0, 16'd2}));
        dir_tab.push_back(mk(ActionArrive[0], 4'hf, 8'd3, 1'b0, '0));
        dir_tab.push_back(mk(ActionArrive[0], 4'd5, 8'd2, 1'b0, '0));
        dir_tab.push_back(mk(ActionArrive[0], 4'd5, 8'd1, 1'b0, '0));
        for (int i = 0; i < 8; i++)
        begin
            dir_tab.push_back(mk(ActionTick[0], 4'(i), 8'(i), 1'b0, '0));
        end
        dir_tab.push_back(mk(ActionArrive[0], 4'd9, 8'hff, 1'b0, '0));
        for (int i = 0; i < 4; i++)
        begin
            dir_tab.push_back(mk(ActionTick[0], 4'hf, 8'hff, 1'b0, '0));
        end
        foreach (dir_tab[i])
        begin
            send_item(dir_tab[i].action, dir_tab[i].pid, dir_tab[i].len, dir_tab[i].known,
                      dir_tab[i].want);
        end
        drain();

        // Mode 1: two long processes alternate, demoted a level per preemption with the quantum doubling per level.
        write_mode(1'b1);
        send_rand(ActionArrive[0], 4'd3, 8'hff);
        send_rand(ActionArrive[0], 4'd4, 8'hff);
        repeat (520) send_rand(ActionTick[0], 4'd0, 8'd0);
        drain();
        write_mode(1'b0);
        // Last level in mode 0: two long processes alternate down through every level.
        send_rand(ActionArrive[0], 4'd1, 8'd60);
        send_rand(ActionArrive[0], 4'd2, 8'd60);
        repeat (130) send_rand(ActionTick[0], 4'd0, 8'd0);
        // Full level: seventeen arrivals into level 0.
        for (int i = 0; i < 17; i++)
        begin
            send_rand(ActionArrive[0], 4'(i), 8'd1);
        end
        drain();

        // Pressure: receiver holds off while ticks keep coming.
        fork
            begin
                rx_hold = 1'b1;
                repeat (STALL_LEN) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                repeat (40) send_rand(ActionTick[0], 4'd0, 8'd0);
            end
        join
        drain();

        // Random phases with various idling patterns and modes.
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 62) : 0;
            rx_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 25 : 62) : 0;
            write_mode(ph[0]);
            random_phase(200, (ph == 0) ? 255 : 12);
            drain();
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_mode(1'b1);
        random_phase(150, 6);
        drain();
        repeat (20) @(posedge clk);

        if (errors == 0)
        begin
            $display("** multilevel_feedback_scheduler: PASSED **");
        end
        else
        begin
            $display("** multilevel_feedback_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
